>>> rtl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Types, constants and helper functions shared by the Playfair encryptor.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int LETTER_W = 5;
    localparam int CELLS    = 25;
    localparam int LETTERS  = 26;

    typedef logic [LETTER_W-1:0] t_letter;   // 0 = A .. 25 = Z
    typedef logic [LETTER_W-1:0] t_cell;     // 0 .. 24, row major
    typedef logic [2:0]          t_coord;    // row or column, 0 .. 4

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;
    localparam t_coord  SIDE_LAST = 3'd4;

    localparam logic [7:0] ASCII_A = 8'd65;
    localparam logic [7:0] ASCII_Z = 8'd90;
    localparam logic [6:0] OUT_A   = 7'd65;

    typedef enum logic [1:0] {
        OP_KEY      = 2'd0,
        OP_KEY_DONE = 2'd1,
        OP_TEXT     = 2'd2,
        OP_TEXT_END = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LA,
        ST_LB,
        ST_LW,
        ST_CELL,
        ST_EMIT,
        ST_ERR
    } t_state;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= ASCII_A) && (c <= ASCII_Z);
    endfunction

    // whitespace and punctuation are silently dropped from the text
    function automatic logic is_dropped(input logic [7:0] c);
        logic d;
        d = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32)
            || ((c >= 8'd33) && (c <= 8'd47))
            || ((c >= 8'd58) && (c <= 8'd64))
            || ((c >= 8'd91) && (c <= 8'd96))
            || ((c >= 8'd123) && (c <= 8'd126));
        return d;
    endfunction

    // letter index with J folded onto I
    function automatic t_letter to_letter(input logic [7:0] c);
        logic [7:0] d;
        t_letter    l;
        d = c - ASCII_A;
        l = d[LETTER_W-1:0];
        if (l == LETTER_J) begin
            l = LETTER_I;
        end
        return l;
    endfunction

    function automatic t_coord cell_row(input t_cell p);
        t_coord r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_coord cell_col(input t_cell p);
        t_coord r;
        t_cell  d;
        r = cell_row(p);
        d = p - {r, 2'b00} - {2'b00, r};
        return d[2:0];
    endfunction

    function automatic t_cell cell_index(input t_coord r, input t_coord c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

>>> rtl/pf_stream_if.sv
// ----------------------------------------------------------------------------
// pf_in_if / pf_out_if
// Valid/ready channels for the command stream and the cipher letter stream.
// ----------------------------------------------------------------------------
interface pf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface pf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;
    logic       last;
    logic       status;

    modport source (output valid, output cipher_char, output last, output status,
                    input ready);
    modport sink   (input valid, input cipher_char, input last, input status,
                    output ready);
endinterface

>>> rtl/playfair_digraph_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair encryptor with key square build, letter pairing and X padding.
// ----------------------------------------------------------------------------
// The square and the letter-to-cell table live in two small RAMs with a
// registered read; one cell-rule unit is reused for both letters of a pair.
// A key byte is handled in ST_IDLE. A key-done beat sweeps the alphabet one letter
// per cycle, and the block takes no beat meanwhile. A text byte that opens a
// pair or is dropped is handled in ST_IDLE; a rejected byte then passes through
// ST_ERR, which waits for a free output slot. The second letter of a pair, or
// a text end that pads with X, runs two table reads, then a rule pass, square
// read and output load for each cipher letter, and waits while output stalls.
// A result waiting in the output register does not block new input beats.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt (
    input logic      i_clk,
    input logic      i_rst_n,
    pf_in_if.sink    i_in,
    pf_out_if.source o_out
);
    import pf_pkg::*;

    t_state              r_state, n_state;
    logic [LETTERS-1:0]  r_used, n_used;
    t_cell               r_fill, n_fill;
    t_letter             r_scan, n_scan;
    logic                r_sq_ready, n_sq_ready;
    t_letter             r_pend, n_pend;
    logic                r_pend_v, n_pend_v;
    t_letter             r_b, n_b;
    t_cell               r_pa, n_pa;
    t_cell               r_pb, n_pb;
    logic                r_second, n_second;
    logic                r_out_valid, n_out_valid;
    logic [6:0]          r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic                r_out_status, n_out_status;

    logic    in_fire;
    logic    slot_free;
    logic    in_upper;
    logic    in_dropped;
    t_letter in_letter;
    logic    place_en;
    logic    do_place;
    t_letter place_idx;
    t_letter lp_raddr;
    t_cell   lp_rdata;
    t_letter sq_rdata;
    t_cell   rule_own, rule_other, rule_cell;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign in_upper   = is_upper(i_in.char_code);
    assign in_dropped = is_dropped(i_in.char_code);
    assign in_letter  = to_letter(i_in.char_code);

    // key letters and the key-done sweep share one placement path
    assign place_idx = (r_state == ST_FILL) ? r_scan : in_letter;
    assign place_en  = (r_state == ST_FILL)
                       || (in_fire && (i_in.opcode == OP_KEY) && !r_sq_ready && in_upper);
    assign do_place  = place_en && (place_idx != LETTER_J) && !r_used[place_idx]
                       && (r_fill < t_cell'(CELLS));

    assign lp_raddr   = (r_state == ST_LA) ? r_pend : r_b;
    assign rule_own   = r_second ? r_pb : r_pa;
    assign rule_other = r_second ? r_pa : r_pb;

    pf_ram #(
        .DATA_W (LETTER_W),
        .DEPTH  (CELLS)
    ) u_square (
        .i_clk   (i_clk),
        .i_we    (do_place),
        .i_waddr (r_fill),
        .i_wdata (place_idx),
        .i_raddr (rule_cell),
        .o_rdata (sq_rdata)
    );

    pf_ram #(
        .DATA_W (LETTER_W),
        .DEPTH  (LETTERS)
    ) u_place (
        .i_clk   (i_clk),
        .i_we    (do_place),
        .i_waddr (place_idx),
        .i_wdata (r_fill),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    pf_rule u_rule (
        .i_own   (rule_own),
        .i_other (rule_other),
        .o_cell  (rule_cell)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (t_op'(i_in.opcode))
                        OP_KEY_DONE: begin
                            if (!r_sq_ready) begin
                                n_state = ST_FILL;
                            end
                        end
                        OP_TEXT: begin
                            if (!in_dropped) begin
                                if (!in_upper || !r_sq_ready) begin
                                    n_state = ST_ERR;
                                end else if (r_pend_v) begin
                                    n_state = ST_LA;
                                end
                            end
                        end
                        OP_TEXT_END: begin
                            if (r_pend_v && r_sq_ready) begin
                                n_state = ST_LA;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (r_scan == t_letter'(LETTERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LA:   n_state = ST_LB;
            ST_LB:   n_state = ST_LW;
            ST_LW:   n_state = ST_CELL;
            ST_CELL: n_state = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = r_second ? ST_IDLE : ST_CELL;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_used       = r_used;
        n_fill       = r_fill;
        n_scan       = r_scan;
        n_sq_ready   = r_sq_ready;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_b          = r_b;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_second     = r_second;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (do_place) begin
            n_used[place_idx] = 1'b1;
            n_fill            = r_fill + t_cell'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (t_op'(i_in.opcode))
                        OP_KEY_DONE: n_scan = '0;
                        OP_TEXT: begin
                            if (!in_dropped && in_upper && r_sq_ready) begin
                                if (!r_pend_v) begin
                                    n_pend   = in_letter;
                                    n_pend_v = 1'b1;
                                end else begin
                                    n_b      = in_letter;
                                    n_pend_v = 1'b0;
                                    n_second = 1'b0;
                                end
                            end
                        end
                        OP_TEXT_END: begin
                            n_b      = LETTER_X;
                            n_pend_v = 1'b0;
                            n_second = 1'b0;
                        end
                        default: n_scan = r_scan;
                    endcase
                end
            end
            ST_FILL: begin
                n_scan = r_scan + t_letter'(1);
                if (r_scan == t_letter'(LETTERS - 1)) begin
                    n_sq_ready = 1'b1;
                end
            end
            ST_LB: n_pa = lp_rdata;
            ST_LW: n_pb = lp_rdata;
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = OUT_A + {2'b00, sq_rdata};
                    n_out_last   = r_second;
                    n_out_status = 1'b0;
                    n_second     = 1'b1;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = 1'b1;
                end
            end
            default: n_second = r_second;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_sq_ready  <= 1'b0;
            r_pend_v    <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_sq_ready  <= n_sq_ready;
            r_pend_v    <= n_pend_v;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_pend       <= n_pend;
        r_b          <= n_b;
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.cipher_char = r_out_char;
    assign o_out.last        = r_out_last;
    assign o_out.status      = r_out_status;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_cell'(CELLS))
        else $error("fill count beyond square size");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_ready |-> (r_fill == t_cell'(CELLS)))
        else $error("square marked ready while not full");

    a_pend_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_sq_ready)
        else $error("pending letter without a finished square");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_second && (r_state == ST_CELL
            || r_state == ST_EMIT)))
        else $error("first cipher letter not followed by second");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_char == '0) && r_out_last)
        else $error("error beat carries a letter");
`endif

endmodule

>>> rtl/pf_ram.sv
// ----------------------------------------------------------------------------
// pf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pf_ram #(
    parameter int DATA_W = pf_pkg::LETTER_W,
    parameter int DEPTH  = pf_pkg::LETTERS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pf_rule.sv
// ----------------------------------------------------------------------------
// pf_rule
// Playfair cell rule: maps one letter's cell to its cipher cell, given the
// cell of the other letter of the pair. Used once per output letter.
// ----------------------------------------------------------------------------
module pf_rule (
    input  pf_pkg::t_cell i_own,
    input  pf_pkg::t_cell i_other,
    output pf_pkg::t_cell o_cell
);
    import pf_pkg::*;

    t_coord own_r, own_c, oth_r, oth_c;
    t_coord res_r, res_c;

    always_comb begin
        own_r = cell_row(i_own);
        own_c = cell_col(i_own);
        oth_r = cell_row(i_other);
        oth_c = cell_col(i_other);
        if (own_r == oth_r) begin
            // same row: step right with wrap
            res_r = own_r;
            res_c = (own_c == SIDE_LAST) ? 3'd0 : own_c + 3'd1;
        end else if (own_c == oth_c) begin
            // same column: step down with wrap
            res_r = (own_r == SIDE_LAST) ? 3'd0 : own_r + 3'd1;
            res_c = own_c;
        end else begin
            // rectangle: keep row, take the other column
            res_r = own_r;
            res_c = oth_c;
        end
    end

    assign o_cell = cell_index(res_r, res_c);

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Playfair encryptor testbench: builds one key square with directed key beats,
// then streams directed and random text through valid/ready channels with
// random stalls on both sides, checking every cipher letter against an
// in-bench model of the square and the pair rules.
// ----------------------------------------------------------------------------
module tb;
    import pf_pkg::*;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       status;
    } t_cipher_beat;

    class cipher_tracker;
        t_letter        grid [CELLS];
        t_cell          where [LETTERS];
        logic [25:0]    placed;
        int unsigned    filled;
        bit             sealed;
        t_letter        held;
        bit             held_valid;
        t_cipher_beat   due_letters [$];
        int             fail_count;

        function new();
            placed     = '0;
            filled     = 0;
            sealed     = 0;
            held       = '0;
            held_valid = 0;
            fail_count = 0;
        endfunction

        function t_letter fold(logic [7:0] c);
            logic [7:0] d;
            t_letter    l;
            d = c - ASCII_A;
            l = d[4:0];
            if (l == LETTER_J) begin
                l = LETTER_I;
            end
            return l;
        endfunction

        function bit silent_byte(logic [7:0] c);
            return (c >= 8'd9 && c <= 8'd13) || c == 8'd32
                || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64)
                || (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
        endfunction

        function void place(t_letter l);
            if (l == LETTER_J || placed[l] || filled >= CELLS) begin
                return;
            end
            grid[filled] = l;
            where[l]     = t_cell'(filled);
            placed[l]    = 1'b1;
            filled++;
        endfunction

        function void encrypt_pair(t_letter a, t_letter b);
            int ra, ca, rb, cb, oa, ob;
            ra = where[a] / 5;
            ca = where[a] % 5;
            rb = where[b] / 5;
            cb = where[b] % 5;
            if (ra == rb) begin
                oa = ra * 5 + (ca + 1) % 5;
                ob = rb * 5 + (cb + 1) % 5;
            end else if (ca == cb) begin
                oa = ((ra + 1) % 5) * 5 + ca;
                ob = ((rb + 1) % 5) * 5 + cb;
            end else begin
                oa = ra * 5 + cb;
                ob = rb * 5 + ca;
            end
            due_letters.push_back('{7'(OUT_A + grid[oa]), 1'b0, 1'b0});
            due_letters.push_back('{7'(OUT_A + grid[ob]), 1'b1, 1'b0});
        endfunction

        function void take_command(t_op op, logic [7:0] c);
            int unsigned k;
            t_letter     l;
            case (op)
                OP_KEY: begin
                    if (!sealed && c >= ASCII_A && c <= ASCII_Z) begin
                        place(fold(c));
                    end
                end
                OP_KEY_DONE: begin
                    if (!sealed) begin
                        for (k = 0; k < LETTERS; k++) begin
                            place(t_letter'(k));
                        end
                        sealed = 1;
                    end
                end
                OP_TEXT: begin
                    if (!silent_byte(c)) begin
                        if (c < ASCII_A || c > ASCII_Z || !sealed) begin
                            // rejected byte, an open pair stays open
                            due_letters.push_back('{7'd0, 1'b1, 1'b1});
                        end else begin
                            l = fold(c);
                            if (!held_valid) begin
                                held       = l;
                                held_valid = 1;
                            end else begin
                                held_valid = 0;
                                encrypt_pair(held, l);
                            end
                        end
                    end
                end
                default: begin
                    if (held_valid && sealed) begin
                        encrypt_pair(held, LETTER_X);
                    end
                    held_valid = 0;
                end
            endcase
        endfunction

        function void match_letter(logic [6:0] ch, logic lst, logic st);
            t_cipher_beat want;
            if (due_letters.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual ch=%0d last=%0d status=%0d",
                         $time, ch, lst, st);
                fail_count++;
                return;
            end
            want = due_letters.pop_front();
            if (want.ch !== ch) begin
                $display("%0t: cipher_char mismatch: expected %0d, actual %0d",
                         $time, want.ch, ch);
                fail_count++;
            end
            if (want.last !== lst) begin
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, want.last, lst);
                fail_count++;
            end
            if (want.status !== st) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle;
    int   snk_idle;

    cipher_tracker tracker;

    pf_in_if  in_ch ();
    pf_out_if out_ch ();

    playfair_digraph_encrypt dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.match_letter(out_ch.cipher_char, out_ch.last, out_ch.status);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_command(t_op op, logic [7:0] c);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.char_code <= c;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        tracker.take_command(op, c);
        @(negedge i_clk);
    endtask

    task automatic random_text(int count);
        int         sent;
        int         pick;
        logic [7:0] prev;
        logic [7:0] c;
        sent = 0;
        prev = ASCII_A;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                // ignored once the square is sealed, not counted
                if ($urandom_range(1) == 1) begin
                    push_command(OP_KEY, 8'($urandom_range(255)));
                end else begin
                    push_command(OP_KEY_DONE, 8'($urandom_range(255)));
                end
            end else begin
                if (pick < 12) begin
                    push_command(OP_TEXT_END, 8'($urandom_range(255)));
                end else if (pick < 26) begin
                    push_command(OP_TEXT, 8'($urandom_range(255)));
                end else begin
                    // doubled letters now and then
                    if ($urandom_range(9) == 0) begin
                        c = prev;
                    end else begin
                        c = ASCII_A + 8'($urandom_range(25));
                    end
                    prev = c;
                    push_command(OP_TEXT, c);
                end
                sent++;
            end
        end
    endtask

    initial begin
        tracker         = new();
        src_idle        = 17;
        snk_idle        = 84;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_KEY;
        in_ch.char_code <= 8'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // text before the square is sealed
        push_command(OP_TEXT, "A");
        push_command(OP_TEXT_END, 8'd0);
        // key with a folded J, a lowercase byte, extreme bytes and a repeat
        push_command(OP_KEY, "P");
        push_command(OP_KEY, "L");
        push_command(OP_KEY, "A");
        push_command(OP_KEY, "Y");
        push_command(OP_KEY, "J");
        push_command(OP_KEY, "a");
        push_command(OP_KEY, 8'hFF);
        push_command(OP_KEY, 8'h00);
        push_command(OP_KEY, "Z");
        push_command(OP_KEY, "A");
        push_command(OP_KEY_DONE, 8'h00);
        push_command(OP_KEY, "Q");
        push_command(OP_KEY_DONE, 8'hFF);
        push_command(OP_TEXT, "H");
        push_command(OP_TEXT, "I");
        push_command(OP_TEXT, "J");
        push_command(OP_TEXT, "J");
        push_command(OP_TEXT, "T");
        push_command(OP_TEXT, "5");
        push_command(OP_TEXT, ".");
        push_command(OP_TEXT, "E");
        push_command(OP_TEXT, 8'h00);
        push_command(OP_TEXT, "Z");
        push_command(OP_TEXT_END, 8'hFF);
        push_command(OP_TEXT_END, 8'h00);
        push_command(OP_TEXT, 8'hFF);

        random_text(350);
        src_idle = 84;
        snk_idle = 17;
        random_text(350);
        src_idle = 0;
        snk_idle = 0;
        random_text(350);
        in_ch.valid <= 1'b0;

        while (tracker.due_letters.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (tracker.due_letters.size() != 0) begin
            $display("%0t: %0d cipher beats never arrived", $time,
                     tracker.due_letters.size());
            tracker.fail_count++;
        end
        if (tracker.fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> playfair_digraph_encrypt.f
rtl/pf_pkg.sv
rtl/pf_stream_if.sv
rtl/pf_ram.sv
rtl/pf_rule.sv
rtl/playfair_digraph_encrypt.sv
sim/tb.sv
